// File: src/subscriber_gap_queue_assert.svh
// assertion macros shared by the subscriber gap queue modules
// no dependencies; modules pass their own clock and reset
`ifndef SUBSCRIBER_GAP_QUEUE_ASSERT_SVH
`define SUBSCRIBER_GAP_QUEUE_ASSERT_SVH

// same-cycle implication
`define SGQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SGQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/sgq_pkg.sv
// types and constants of the subscriber gap queue
// no dependencies
package sgq_pkg;

  localparam int PAY_W  = 32;
  localparam int SEQ_W  = 64;
  localparam int TIME_W = 63;
  localparam int CNT_W  = 9;

  localparam logic [SEQ_W-1:0] SEQ_MAX = '1;

  localparam logic [3:0] OP_STAGE     = 4'd0;
  localparam logic [3:0] OP_ADMIT     = 4'd1;
  localparam logic [3:0] OP_REPLACE   = 4'd2;
  localparam logic [3:0] OP_UNAVAIL   = 4'd3;
  localparam logic [3:0] OP_QUERY     = 4'd4;
  localparam logic [3:0] OP_ACK_ENTRY = 4'd5;
  localparam logic [3:0] OP_ACK_TERM  = 4'd6;
  localparam logic [3:0] OP_OWNER_CLS = 4'd7;
  localparam logic [3:0] OP_WRITER_CLS = 4'd8;

  localparam logic [2:0] RS_OK       = 3'd0;
  localparam logic [2:0] RS_REFUSED  = 3'd1;
  localparam logic [2:0] RS_INACTIVE = 3'd2;
  localparam logic [2:0] RS_ALLOC    = 3'd3;
  localparam logic [2:0] RS_TERMINAL = 3'd4;
  localparam logic [2:0] RS_MISMATCH = 3'd5;
  localparam logic [2:0] RS_CLOSED   = 3'd6;

  localparam logic [1:0] CH_ACTIVE  = 2'd0;
  localparam logic [1:0] CH_GAP     = 2'd1;
  localparam logic [1:0] CH_UNAVAIL = 2'd2;
  localparam logic [1:0] CH_CLOSED  = 2'd3;

  localparam logic [1:0] HK_NONE = 2'd0;
  localparam logic [1:0] HK_RING = 2'd1;
  localparam logic [1:0] HK_GAP  = 2'd2;

  localparam logic CFG_STREAM = 1'b0;
  localparam logic CFG_CAP    = 1'b1;

  localparam logic [1:0]       STREAM_RST = 2'd1;
  localparam logic [CNT_W-1:0] CAP_RST    = 9'd256;

  typedef struct packed {
    logic [3:0]        opcode;
    logic [1:0]        event_stream;
    logic [PAY_W-1:0]  payload_handle;
    logic [TIME_W-1:0] time_ns;
    logic [SEQ_W-1:0]  ack_sequence;
    logic              ack_reason;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [1:0]        channel_state;
    logic [CNT_W-1:0]  queue_count;
    logic [SEQ_W-1:0]  next_sequence;
    logic              gap_pending;
    logic [1:0]        head_kind;
    logic [PAY_W-1:0]  head_payload;
    logic [SEQ_W-1:0]  head_sequence;
    logic [TIME_W-1:0] head_time;
    logic              head_reason;
  } out_beat_t;

  typedef struct packed {
    logic [PAY_W-1:0]  payload;
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] stamp;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef struct packed {
    logic [2:0]        status;
    logic [1:0]        chan;
    logic [CNT_W-1:0]  count;
    logic [SEQ_W-1:0]  seq;
    logic              gap_valid;
    logic [SEQ_W-1:0]  gap_seq;
    logic [TIME_W-1:0] gap_time;
    logic              gap_reason;
  } view_t;

endpackage

// File: src/sgq_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module sgq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/sgq_core.sv
// channel state registers and operation decode of the subscriber gap queue
// depends on sgq_pkg and the assertion macro header
`include "subscriber_gap_queue_assert.svh"

module sgq_core #(
  parameter int QUEUE_DEPTH = 256,
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    exec_en,
  input  sgq_pkg::in_beat_t       beat,
  input  sgq_pkg::rec_t           head_rec,
  input  logic [1:0]              cfg_stream,
  input  logic [sgq_pkg::CNT_W-1:0] cfg_cap,
  output logic [AW-1:0]           head_idx,
  output logic [AW-1:0]           head_nxt_idx,
  output logic                    wr_en,
  output logic [AW-1:0]           wr_addr,
  output sgq_pkg::rec_t           wr_rec,
  output sgq_pkg::view_t          view
);

  localparam int SW = ((AW > sgq_pkg::CNT_W) ? AW : sgq_pkg::CNT_W) + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);
  localparam logic [AW:0]   DEPTH_H = (AW+1)'(QUEUE_DEPTH);

  logic [1:0]                  chan_r, chan_nxt;
  logic [sgq_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [AW-1:0]               head_r, head_nxt;
  logic [sgq_pkg::SEQ_W-1:0]   seq_r, seq_nxt;
  logic                        gval_r, gval_nxt;
  logic [sgq_pkg::SEQ_W-1:0]   gseq_r, gseq_nxt;
  logic [sgq_pkg::TIME_W-1:0]  gtime_r, gtime_nxt;
  logic                        grsn_r, grsn_nxt;
  logic [2:0]                  status_r, status_nxt;

  logic [SW-1:0] sum_s, tail_s, cap_s, cap_eff;
  logic [AW:0]   head_inc;
  logic [AW-1:0] tail, head_wrap;
  logic          full, pay_nz, stream_ok;

  always_comb begin
    sum_s  = SW'(head_r) + SW'(count_r);
    tail_s = (sum_s >= DEPTH_S) ? sum_s - DEPTH_S : sum_s;
    tail   = tail_s[AW-1:0];
    cap_s  = SW'(cfg_cap);
    if (cap_s == '0) begin
      cap_eff = SW'(1);
    end else if (cap_s > DEPTH_S) begin
      cap_eff = DEPTH_S;
    end else begin
      cap_eff = cap_s;
    end
    full      = SW'(count_r) >= cap_eff;
    head_inc  = {1'b0, head_r} + (AW+1)'(1);
    head_wrap = (head_inc == DEPTH_H) ? '0 : head_inc[AW-1:0];
    pay_nz    = beat.payload_handle != '0;
    stream_ok = (beat.event_stream != 2'd0) && (beat.event_stream == cfg_stream);
  end

  always_comb begin
    chan_nxt   = chan_r;
    count_nxt  = count_r;
    head_nxt   = head_r;
    seq_nxt    = seq_r;
    gval_nxt   = gval_r;
    gseq_nxt   = gseq_r;
    gtime_nxt  = gtime_r;
    grsn_nxt   = grsn_r;
    status_nxt = sgq_pkg::RS_REFUSED;
    wr_en      = 1'b0;
    wr_addr    = tail;
    wr_rec     = '{payload: beat.payload_handle, seq: seq_r, stamp: beat.time_ns};
    case (beat.opcode)
      sgq_pkg::OP_STAGE: begin
        if (pay_nz && chan_r == sgq_pkg::CH_ACTIVE && count_r == '0) begin
          wr_en      = exec_en;
          wr_rec.seq = sgq_pkg::SEQ_W'(1);
          count_nxt  = count_r + 1'b1;
          seq_nxt    = sgq_pkg::SEQ_W'(2);
          status_nxt = sgq_pkg::RS_OK;
        end
      end
      sgq_pkg::OP_ADMIT: begin
        if (chan_r != sgq_pkg::CH_ACTIVE) begin
          status_nxt = sgq_pkg::RS_INACTIVE;
        end else if (!pay_nz || !stream_ok) begin
          status_nxt = sgq_pkg::RS_ALLOC;
        end else if (full) begin
          gval_nxt   = 1'b1;
          gseq_nxt   = seq_r;
          gtime_nxt  = beat.time_ns;
          grsn_nxt   = 1'b0;
          seq_nxt    = (seq_r != sgq_pkg::SEQ_MAX) ? seq_r + 1'b1 : seq_r;
          chan_nxt   = sgq_pkg::CH_GAP;
          status_nxt = sgq_pkg::RS_TERMINAL;
        end else if (seq_r == sgq_pkg::SEQ_MAX) begin
          status_nxt = sgq_pkg::RS_ALLOC;
        end else begin
          wr_en      = exec_en;
          count_nxt  = count_r + 1'b1;
          seq_nxt    = seq_r + 1'b1;
          status_nxt = sgq_pkg::RS_OK;
        end
      end
      sgq_pkg::OP_REPLACE: begin
        if (chan_r == sgq_pkg::CH_ACTIVE && !gval_r) begin
          gval_nxt   = 1'b1;
          gseq_nxt   = seq_r;
          gtime_nxt  = beat.time_ns;
          grsn_nxt   = 1'b1;
          seq_nxt    = (seq_r != sgq_pkg::SEQ_MAX) ? seq_r + 1'b1 : seq_r;
          chan_nxt   = sgq_pkg::CH_GAP;
          status_nxt = sgq_pkg::RS_OK;
        end
      end
      sgq_pkg::OP_UNAVAIL: begin
        if (chan_r == sgq_pkg::CH_ACTIVE) begin
          chan_nxt   = sgq_pkg::CH_UNAVAIL;
          status_nxt = sgq_pkg::RS_OK;
        end
      end
      sgq_pkg::OP_QUERY: begin
        status_nxt = sgq_pkg::RS_OK;
      end
      sgq_pkg::OP_ACK_ENTRY: begin
        if (chan_r == sgq_pkg::CH_CLOSED) begin
          status_nxt = sgq_pkg::RS_CLOSED;
        end else if (count_r == '0 || head_rec.seq != beat.ack_sequence) begin
          status_nxt = sgq_pkg::RS_MISMATCH;
        end else begin
          head_nxt   = head_wrap;
          count_nxt  = count_r - 1'b1;
          status_nxt = sgq_pkg::RS_OK;
        end
      end
      sgq_pkg::OP_ACK_TERM: begin
        if (chan_r == sgq_pkg::CH_CLOSED) begin
          status_nxt = sgq_pkg::RS_CLOSED;
        end else if (count_r == '0 && gval_r && gseq_r == beat.ack_sequence &&
                     grsn_r == beat.ack_reason && gtime_r == beat.time_ns) begin
          gval_nxt   = 1'b0;
          chan_nxt   = sgq_pkg::CH_CLOSED;
          status_nxt = sgq_pkg::RS_CLOSED;
        end else begin
          status_nxt = sgq_pkg::RS_MISMATCH;
        end
      end
      sgq_pkg::OP_OWNER_CLS: begin
        chan_nxt   = sgq_pkg::CH_CLOSED;
        status_nxt = sgq_pkg::RS_OK;
      end
      sgq_pkg::OP_WRITER_CLS: begin
        chan_nxt   = sgq_pkg::CH_CLOSED;
        head_nxt   = tail;
        count_nxt  = '0;
        gval_nxt   = 1'b0;
        status_nxt = sgq_pkg::RS_OK;
      end
      default: begin
        status_nxt = sgq_pkg::RS_REFUSED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r   <= sgq_pkg::CH_ACTIVE;
      count_r  <= '0;
      head_r   <= '0;
      seq_r    <= sgq_pkg::SEQ_W'(1);
      gval_r   <= 1'b0;
      gseq_r   <= '0;
      gtime_r  <= '0;
      grsn_r   <= 1'b0;
      status_r <= sgq_pkg::RS_OK;
    end else if (exec_en) begin
      chan_r   <= chan_nxt;
      count_r  <= count_nxt;
      head_r   <= head_nxt;
      seq_r    <= seq_nxt;
      gval_r   <= gval_nxt;
      gseq_r   <= gseq_nxt;
      gtime_r  <= gtime_nxt;
      grsn_r   <= grsn_nxt;
      status_r <= status_nxt;
    end
  end

  assign head_idx     = head_r;
  assign head_nxt_idx = head_nxt;
  assign view = '{status: status_r, chan: chan_r, count: count_r, seq: seq_r,
                  gap_valid: gval_r, gap_seq: gseq_r, gap_time: gtime_r,
                  gap_reason: grsn_r};

  `SGQ_ASSERT_NOW(a_count_in_depth, clk, rst_n, 1'b1, SW'(count_r) <= DEPTH_S,
    "ring count beyond depth")
  `SGQ_ASSERT_NOW(a_gap_not_active, clk, rst_n, gval_r, chan_r != sgq_pkg::CH_ACTIVE,
    "gap descriptor on an active channel")
  `SGQ_ASSERT_NEXT(a_push_counts, clk, rst_n, wr_en, count_r == $past(count_r) + 1'b1,
    "ring write without count increment")

endmodule

// File: src/subscriber_gap_queue.sv
// top level of the subscriber gap queue: sequencer, ring memory, result register
// depends on sgq_pkg, sgq_core, sgq_ram and the assertion macro header
//
// usage
//   in_valid/in_ready/in_beat carry one operation per beat; out_valid/out_ready/out_beat
//   return exactly one result beat per operation, in order.
//   cfg_we/cfg_index/cfg_wdata write accepted_stream (index 0) or capacity_in_use
//   (index 1); write only while no operation is in flight.
//   an operation passes through accept (ring head read issued), execute
//   (state update, ring write, read of the new head) and result capture. the two
//   dependent reads of the single-read-port ring are issued in accept and execute;
//   a new beat is taken only once the previous result has been captured.
//   the result register frees the sequencer: a new beat is accepted while a
//   result waits; a second result waits in the sequencer until out_ready.
//   reset (rst_n low, synchronous) gives an active, empty channel, sequence one,
//   no descriptor, accepted_stream 1, capacity 256; the ring needs no clearing.
`include "subscriber_gap_queue_assert.svh"

module subscriber_gap_queue #(
  parameter int QUEUE_DEPTH = 256,
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  sgq_pkg::in_beat_t         in_beat,
  output logic                      out_valid,
  input  logic                      out_ready,
  output sgq_pkg::out_beat_t        out_beat,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [sgq_pkg::CNT_W-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DONE = 3'b100
  } seq_state_t;

  seq_state_t state_r, state_nxt;

  logic [1:0]                stream_r;
  logic [sgq_pkg::CNT_W-1:0] cap_r;
  sgq_pkg::in_beat_t         in_r;
  logic                      out_valid_r, out_valid_nxt;
  sgq_pkg::out_beat_t        out_r, res;
  logic                      fwd_hit_r;
  sgq_pkg::rec_t             fwd_rec_r;

  logic                      in_fire, exec_en, load_out;
  logic [AW-1:0]             head_idx, head_nxt_idx, rd_addr, wr_addr;
  logic                      wr_en, rd_en;
  sgq_pkg::rec_t             wr_rec, rd_rec, head_rec;
  logic [sgq_pkg::REC_W-1:0] rd_data;
  sgq_pkg::view_t            view;

  assign in_ready = state_r == S_IDLE;
  assign in_fire  = in_valid && in_ready;
  assign exec_en  = state_r == S_EXEC;
  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign rd_en    = in_fire || exec_en;
  assign rd_addr  = exec_en ? head_nxt_idx : head_idx;
  assign rd_rec   = sgq_pkg::rec_t'(rd_data);

  sgq_core #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .exec_en      (exec_en),
    .beat         (in_r),
    .head_rec     (rd_rec),
    .cfg_stream   (stream_r),
    .cfg_cap      (cap_r),
    .head_idx     (head_idx),
    .head_nxt_idx (head_nxt_idx),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_rec       (wr_rec),
    .view         (view)
  );

  sgq_ram #(.WIDTH(sgq_pkg::REC_W), .DEPTH(QUEUE_DEPTH)) u_ring (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_rec),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // peek view after the operation
  always_comb begin
    head_rec = fwd_hit_r ? fwd_rec_r : rd_rec;
    res = '0;
    res.status        = view.status;
    res.channel_state = view.chan;
    res.queue_count   = view.count;
    res.next_sequence = view.seq;
    res.gap_pending   = view.gap_valid;
    res.head_kind     = sgq_pkg::HK_NONE;
    if (view.chan != sgq_pkg::CH_CLOSED) begin
      if (view.count != '0) begin
        res.head_kind     = sgq_pkg::HK_RING;
        res.head_payload  = head_rec.payload;
        res.head_sequence = head_rec.seq;
        res.head_time     = head_rec.stamp;
      end else if (view.gap_valid) begin
        res.head_kind     = sgq_pkg::HK_GAP;
        res.head_sequence = view.gap_seq;
        res.head_time     = view.gap_time;
        res.head_reason   = view.gap_reason;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      stream_r    <= sgq_pkg::STREAM_RST;
      cap_r       <= sgq_pkg::CAP_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          sgq_pkg::CFG_STREAM: stream_r <= cfg_wdata[1:0];
          sgq_pkg::CFG_CAP:    cap_r    <= cfg_wdata;
          default:             cap_r    <= cap_r;
        endcase
      end
    end
  end

  // same-entry write and read in the execute cycle: forward the written record
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_r <= in_beat;
    end
    if (exec_en) begin
      fwd_hit_r <= wr_en && (wr_addr == rd_addr);
      fwd_rec_r <= wr_rec;
    end
    if (load_out) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

  `SGQ_ASSERT_NOW(a_write_in_exec, clk, rst_n, wr_en, state_r == S_EXEC,
    "ring write outside execute cycle")
  `SGQ_ASSERT_NEXT(a_fire_to_exec, clk, rst_n, in_fire, state_r == S_EXEC,
    "accepted beat not executed next cycle")
  `SGQ_ASSERT_NEXT(a_exec_to_done, clk, rst_n, exec_en, state_r == S_DONE,
    "execute not followed by result capture")

endmodule
